@@ rtl/nte_pkg.sv @@
// Shared types and constants for the expression node table evaluator.
`timescale 1ns / 1ps
package nte_pkg;

	localparam int VAL_W = 64;

	typedef enum logic [4:0] {
		OP_CONST = 5'd0,
		OP_PARAM = 5'd1,
		OP_ADD   = 5'd2,
		OP_SUB   = 5'd3,
		OP_MUL   = 5'd4,
		OP_DIV   = 5'd5,
		OP_MOD   = 5'd6,
		OP_MIN   = 5'd7,
		OP_MAX   = 5'd8,
		OP_NEG   = 5'd9,
		OP_ABS   = 5'd10,
		OP_LT    = 5'd11,
		OP_LE    = 5'd12,
		OP_EQ    = 5'd13,
		OP_AND   = 5'd14,
		OP_OR    = 5'd15,
		OP_NOT   = 5'd16
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_UNKNOWN_OP = 3'd1,
		ST_PARAM_RNG  = 3'd2,
		ST_BAD_A      = 3'd3,
		ST_BAD_B      = 3'd4,
		ST_DIV_ZERO   = 3'd5,
		ST_TABLE_FULL = 3'd6,
		ST_ABORTED    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV
	} state_t;

	localparam logic CMD_LOAD = 1'b0;

endpackage

@@ rtl/expression_node_table_evaluator.sv @@
// Top level: node and parameter memories, node sequencer and arithmetic.
// A load word is taken when start is seen while idle and gives no result; busy stays low.
// An evaluate word gives its result from the execute state for simple ops and errors, from the
// multiplier for mul and from the divider for div or mod; busy is high meanwhile.
// The receiver cannot stall: done marks each result for exactly one cycle.
// After reset busy stays high while the parameter memory is zeroed.
`timescale 1ns / 1ps
module expression_node_table_evaluator
	import nte_pkg::*;
#(
	parameter int MAX_NODES  = 256,
	parameter int MAX_PARAMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic               first_node,
	input  logic [4:0]         opcode,
	input  logic [7:0]         operand_a,
	input  logic               has_a,
	input  logic [7:0]         operand_b,
	input  logic               has_b,
	input  logic signed [63:0] immediate,
	input  logic [5:0]         param_slot,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_data,
	output logic               done,
	output logic [7:0]         node_index,
	output logic signed [63:0] node_value,
	output logic [2:0]         status
);

	localparam int NAW  = $clog2(MAX_NODES);
	localparam int PAW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;

	logic [VAL_W-1:0] node_mem  [MAX_NODES];
	logic [VAL_W-1:0] param_mem [MAX_PARAMS];

	state_t           state_q, state_d;
	logic [PAW-1:0]   clr_q;
	logic [6:0]       param_count_q;
	logic [CW-1:0]    counter_q;
	logic             failed_q;

	logic [CW-1:0]    idx_s1;
	opcode_t          op_s1;
	status_t          status_s1;
	logic [VAL_W-1:0] imm_s1;
	logic [VAL_W-1:0] a_rd, b_rd, p_rd;

	logic             done_q;
	logic [7:0]       index_q;
	logic [VAL_W-1:0] value_q;
	status_t          status_q;

	logic             accept, eval_accept;
	logic [CW-1:0]    idx_eff;
	logic             failed_eff, unary, binary, param_bad;
	status_t          status_in;

	logic             complete, mul_start, div_start;
	logic [VAL_W-1:0] fin_value, alu_value;
	status_t          fin_status;
	logic [VAL_W-1:0] mag_a, mag_b;
	logic             na, nb;

	logic [VAL_W-1:0] mul_p, div_q, div_r;
	logic             mul_done, div_done;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign eval_accept = accept && (command != CMD_LOAD);

	// Validation of an incoming node, in priority order.
	always_comb begin
		idx_eff    = first_node ? '0 : counter_q;
		failed_eff = first_node ? 1'b0 : failed_q;
		unary      = (opcode inside {OP_NEG, OP_ABS, OP_NOT});
		binary     = (opcode inside {[OP_ADD:OP_NOT]}) && !unary;
		param_bad  = immediate[63]
			|| ($unsigned(immediate) >= 64'(param_count_q))
			|| ($unsigned(immediate) >= 64'(MAX_PARAMS));
		if (failed_eff)
			status_in = ST_ABORTED;
		else if (idx_eff >= CW'(MAX_NODES))
			status_in = ST_TABLE_FULL;
		else if (opcode > OP_NOT)
			status_in = ST_UNKNOWN_OP;
		else if ((opcode == OP_PARAM) && param_bad)
			status_in = ST_PARAM_RNG;
		else if ((unary || binary) && (!has_a || (CMPW'(operand_a) >= CMPW'(idx_eff))))
			status_in = ST_BAD_A;
		else if (binary && (!has_b || (CMPW'(operand_b) >= CMPW'(idx_eff))))
			status_in = ST_BAD_B;
		else
			status_in = ST_OK;
	end

	always_comb begin
		alu_value = '0;
		case (op_s1)
			OP_CONST: alu_value = imm_s1;
			OP_PARAM: alu_value = p_rd;
			OP_ADD:   alu_value = a_rd + b_rd;
			OP_SUB:   alu_value = a_rd - b_rd;
			OP_MIN:   alu_value = ($signed(a_rd) < $signed(b_rd)) ? a_rd : b_rd;
			OP_MAX:   alu_value = ($signed(b_rd) < $signed(a_rd)) ? a_rd : b_rd;
			OP_NEG:   alu_value = -a_rd;
			OP_ABS:   alu_value = a_rd[63] ? -a_rd : a_rd;
			OP_LT:    alu_value = 64'(($signed(a_rd) < $signed(b_rd)));
			OP_LE:    alu_value = 64'(!($signed(b_rd) < $signed(a_rd)));
			OP_EQ:    alu_value = 64'((a_rd == b_rd));
			OP_AND:   alu_value = 64'(((a_rd != '0) && (b_rd != '0)));
			OP_OR:    alu_value = 64'(((a_rd != '0) || (b_rd != '0)));
			OP_NOT:   alu_value = 64'((a_rd == '0));
			default:  alu_value = '0;
		endcase
	end

	assign na    = a_rd[63];
	assign nb    = b_rd[63];
	assign mag_a = na ? -a_rd : a_rd;
	assign mag_b = nb ? -b_rd : b_rd;

	always_comb begin
		state_d    = state_q;
		complete   = 1'b0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		fin_value  = '0;
		fin_status = status_s1;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == PAW'(MAX_PARAMS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (eval_accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (status_s1 != ST_OK) begin
					complete = 1'b1;
				end else if (op_s1 == OP_MUL) begin
					mul_start = 1'b1;
					state_d   = S_MUL;
				end else if (op_s1 == OP_DIV || op_s1 == OP_MOD) begin
					if (b_rd == '0) begin
						complete   = 1'b1;
						fin_status = ST_DIV_ZERO;
					end else begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end
				end else begin
					complete  = 1'b1;
					fin_value = alu_value;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					complete  = 1'b1;
					fin_value = mul_p;
				end
			end
			S_DIV: begin
				if (div_done) begin
					complete = 1'b1;
					// Floor rounding: a nonzero remainder with mixed signs moves the
					// quotient down by one and the remainder over to the divisor's sign.
					if (div_r == '0 || na == nb) begin
						if (op_s1 == OP_DIV)
							fin_value = (na != nb) ? -div_q : div_q;
						else
							fin_value = na ? -div_r : div_r;
					end else begin
						if (op_s1 == OP_DIV)
							fin_value = ~div_q;
						else
							fin_value = na ? (b_rd - div_r) : (b_rd + div_r);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (complete)
			state_d = S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			param_count_q <= '0;
			counter_q     <= '0;
			failed_q      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= complete;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + PAW'(1);
			if (cfg_we)
				param_count_q <= cfg_data;
			if (complete) begin
				failed_q <= (fin_status != ST_OK);
				// Nodes beyond the table neither advance the counter nor touch memory.
				if (idx_s1 < CW'(MAX_NODES))
					counter_q <= idx_s1 + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_accept) begin
			idx_s1    <= idx_eff;
			op_s1     <= opcode_t'(opcode);
			status_s1 <= status_in;
			imm_s1    <= immediate;
		end
		if (complete) begin
			index_q  <= 8'(idx_s1);
			value_q  <= fin_value;
			status_q <= fin_status;
		end
	end

	// Node memory: written once per finished node, read at two operand addresses.
	always_ff @(posedge clk) begin
		if (complete && idx_s1 < CW'(MAX_NODES))
			node_mem[idx_s1[NAW-1:0]] <= fin_value;
		if (eval_accept) begin
			a_rd <= node_mem[NAW'(operand_a)];
			b_rd <= node_mem[NAW'(operand_b)];
		end
	end

	// Parameter memory: zeroed after reset, then written by load words.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			param_mem[clr_q] <= '0;
		else if (accept && command == CMD_LOAD && (32'(param_slot) < MAX_PARAMS))
			param_mem[PAW'(param_slot)] <= immediate;
		if (eval_accept)
			p_rd <= param_mem[immediate[PAW-1:0]];
	end

	nte_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (a_rd),
		.b       (b_rd),
		.product (mul_p),
		.done    (mul_done)
	);

	nte_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag_a),
		.divisor   (mag_b),
		.quotient  (div_q),
		.remainder (div_r),
		.done      (div_done)
	);

	assign done       = done_q;
	assign node_index = index_q;
	assign node_value = value_q;
	assign status     = status_q;

endmodule

@@ rtl/nte_mul.sv @@
// Sequential 64-bit wrapping multiplier built from one shared 32x32 multiplier.
`timescale 1ns / 1ps
module nte_mul
	import nte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	output logic [VAL_W-1:0] product,
	output logic             done
);

	logic [VAL_W-1:0] a_q, b_q, prod_q, acc_q;
	logic [1:0]       phase_q;
	logic             run_q, done_q;
	logic [31:0]      mx_a, mx_b;

	// Only the low 64 bits are kept, so the high-by-high product is never needed.
	always_comb begin
		mx_a = (phase_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		mx_b = (phase_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= 2'd0;
			end else if (run_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (run_q) begin
			prod_q <= mx_a * mx_b;
			case (phase_q)
				2'd0: begin
				end
				2'd1: acc_q <= prod_q;
				default: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
			endcase
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

@@ rtl/nte_div.sv @@
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nte_div
	import nte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic [VAL_W-1:0] quotient,
	output logic [VAL_W-1:0] remainder,
	output logic             done
);

	logic [VAL_W-1:0] rem_q, quo_q, dsr_q;
	logic [6:0]       cnt_q;
	logic             run_q, done_q;
	logic [VAL_W:0]   shifted, diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[VAL_W-1]};
		ge      = shifted >= {1'b0, dsr_q};
		diff    = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(VAL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule
